// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tps_pkg.sv =====
`timescale 1ns / 1ps
package tps_pkg;

  localparam int SHAPED_BITS = 29;
  localparam int DELAY_BITS  = 12;
  localparam int TAP_BITS    = DELAY_BITS + 1;   // holds rise_k + delay_l

  localparam logic [DELAY_BITS-1:0] RISE_K_RESET  = 12'd2500;
  localparam logic [DELAY_BITS-1:0] DELAY_L_RESET = 12'd3000;

  // register word index, taken from paddr[2]
  localparam logic REG_RISE_K  = 1'b0;
  localparam logic REG_DELAY_L = 1'b1;

  // where a tap value comes from
  typedef enum logic [1:0] {
    TAP_ZERO,
    TAP_CUR,
    TAP_MEM
  } tap_sel_t;

endpackage

// ===== rtl/tps_ifs.sv =====
`timescale 1ns / 1ps
interface tps_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface tps_out_if
  import tps_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SHAPED_BITS-1:0] shaped;

  modport source (output valid, output shaped, input ready);
  modport sink   (input valid, input shaped, output ready);
endinterface

// ===== rtl/tps_ram.sv =====
`timescale 1ns / 1ps
module tps_ram #(
  parameter int WIDTH    = 16,
  parameter int DEPTH    = 8192,
  parameter int RD_PORTS = 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr [RD_PORTS],
  output logic [WIDTH-1:0]         rd_data [RD_PORTS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data[p] <= mem[rd_addr[p]];
      end
    end
  end

endmodule

// ===== rtl/trapezoidal_pulse_shaper.sv =====
// Trapezoidal pulse shaper, delay-difference form:
//   shaped[n] = shaped[n-1] + x[n] - x[n-k] - x[n-l] + x[n-l-k]
// Input channel sample_ch carries one signed sample and a start_req flag per
// transfer; start_req marks the first sample of a record, which restarts the
// running sum and makes all earlier history read as zero. Output channel
// shaped_ch carries one 29-bit signed result per input transfer, in order.
// k (rise_k) and delay l (delay_l) sit behind an APB-style port at byte
// addresses 0 and 4; write them only while the shaper is idle.
// Pipeline: the RAM read registers at the edge that accepts a sample, then
// the tap sum is registered, then the running sum, which drives shaped_ch.
// Throughput: one sample per cycle unless shaped_ch stalls, set by the single
// write port of the history RAMs; the three delayed taps are read in the same
// cycle from two RAMs (one dual-read, one single-read) with identical writes.
// Reset: clears control state, fill count, write pointer and running sum; the
// history RAMs are not cleared, the fill count keeps any unwritten entry
// from being used, so a sample can be taken as soon as reset is released.
// Stall: the three stages advance independently, so input transfers go on
// while a result waits, until every stage holds an item; then ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trapezoidal_pulse_shaper
  import tps_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  tps_in_if.sink      sample_ch,
  tps_out_if.source   shaped_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  // compare width wide enough for tap delays and for HISTORY_DEPTH itself
  localparam int CW = ((AW > TAP_BITS) ? AW : TAP_BITS) + 1;
  // x - a - b + c of SAMPLE_BITS values
  localparam int PW = SAMPLE_BITS + 2;
  localparam logic [AW-1:0] FC_MAX = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0] WP_MAX = AW'(HISTORY_DEPTH - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DELAY_BITS-1:0] rise_k;
  logic [DELAY_BITS-1:0] delay_l;
  logic                  cfg_wr;
  logic                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];   // word select; byte lanes ignored

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_k  <= RISE_K_RESET;
      delay_l <= DELAY_L_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RISE_K:  rise_k  <= pwdata[DELAY_BITS-1:0];
        REG_DELAY_L: delay_l <= pwdata[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RISE_K:  prdata = 32'(rise_k);
      REG_DELAY_L: prdata = 32'(delay_l);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage enables: each stage loads when empty or when it empties itself
  // ---------------------------------------------------------------------
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic in_fire;

  assign en3 = !v3 || shaped_ch.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sample_ch.ready = en1;
  assign in_fire = sample_ch.valid && en1;

  // ---------------------------------------------------------------------
  // Stage 0: tap decode, RAM read issue, history write
  // ---------------------------------------------------------------------
  logic [AW-1:0]       fill_count;
  logic [AW-1:0]       wp;
  logic [AW-1:0]       fc_eff;
  logic [TAP_BITS-1:0] d_k, d_l, d_kl;
  tap_sel_t            sel_k, sel_l, sel_kl;

  function automatic tap_sel_t tap_select(input logic [TAP_BITS-1:0] d,
                                          input logic [AW-1:0] fc);
    logic [CW-1:0] dx;
    logic [CW-1:0] fx;
    dx = CW'(d);
    fx = CW'(fc);
    if (d == '0) return TAP_CUR;
    else if (dx > fx || dx >= CW'(HISTORY_DEPTH)) return TAP_ZERO;
    else return TAP_MEM;
  endfunction

  // ring slot d entries behind the write pointer
  function automatic logic [AW-1:0] tap_addr(input logic [TAP_BITS-1:0] d,
                                             input logic [AW-1:0] ptr);
    logic [CW-1:0] diff;
    diff = CW'(ptr) - CW'(d);
    if (CW'(ptr) < CW'(d)) diff = diff + CW'(HISTORY_DEPTH);
    return diff[AW-1:0];
  endfunction

  assign fc_eff = sample_ch.start_req ? '0 : fill_count;
  assign d_k    = TAP_BITS'(rise_k);
  assign d_l    = TAP_BITS'(delay_l);
  assign d_kl   = TAP_BITS'(rise_k) + TAP_BITS'(delay_l);
  assign sel_k  = tap_select(d_k, fc_eff);
  assign sel_l  = tap_select(d_l, fc_eff);
  assign sel_kl = tap_select(d_kl, fc_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wp         <= '0;
    end else if (in_fire) begin
      fill_count <= (fc_eff == FC_MAX) ? FC_MAX : fc_eff + 1'b1;
      wp         <= (wp == WP_MAX) ? '0 : wp + 1'b1;
    end
  end

  // Reads whose data is used only touch slots at least one behind the slot
  // written this cycle, and writes land at the edge, so no forwarding is needed.
  logic [AW-1:0]          ram_a_addr [2];
  logic [SAMPLE_BITS-1:0] ram_a_data [2];
  logic [AW-1:0]          ram_b_addr [1];
  logic [SAMPLE_BITS-1:0] ram_b_data [1];

  assign ram_a_addr[0] = tap_addr(d_k, wp);
  assign ram_a_addr[1] = tap_addr(d_l, wp);
  assign ram_b_addr[0] = tap_addr(d_kl, wp);

  tps_ram #(
    .WIDTH   (SAMPLE_BITS),
    .DEPTH   (HISTORY_DEPTH),
    .RD_PORTS(2)
  ) u_hist_a (
    .clk    (clk),
    .wr_en  (in_fire),
    .wr_addr(wp),
    .wr_data(sample_ch.sample),
    .rd_en  (en1),
    .rd_addr(ram_a_addr),
    .rd_data(ram_a_data)
  );

  tps_ram #(
    .WIDTH   (SAMPLE_BITS),
    .DEPTH   (HISTORY_DEPTH),
    .RD_PORTS(1)
  ) u_hist_b (
    .clk    (clk),
    .wr_en  (in_fire),
    .wr_addr(wp),
    .wr_data(sample_ch.sample),
    .rd_en  (en1),
    .rd_addr(ram_b_addr),
    .rd_data(ram_b_data)
  );

  // ---------------------------------------------------------------------
  // Stage 1: RAM data arrives, combine the four taps
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_start;
  tap_sel_t                      s1_sel_k, s1_sel_l, s1_sel_kl;
  logic signed [SAMPLE_BITS-1:0] tk, tl, tkl;
  logic signed [PW-1:0]          partial;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= sample_ch.sample;
      s1_start  <= sample_ch.start_req;
      s1_sel_k  <= sel_k;
      s1_sel_l  <= sel_l;
      s1_sel_kl <= sel_kl;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] tap_val(
    input tap_sel_t                      sel,
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic        [SAMPLE_BITS-1:0] mem
  );
    case (sel)
      TAP_CUR: return cur;
      TAP_MEM: return $signed(mem);
      default: return '0;
    endcase
  endfunction

  assign tk      = tap_val(s1_sel_k, s1_sample, ram_a_data[0]);
  assign tl      = tap_val(s1_sel_l, s1_sample, ram_a_data[1]);
  assign tkl     = tap_val(s1_sel_kl, s1_sample, ram_b_data[0]);
  assign partial = PW'(s1_sample) - PW'(tk) - PW'(tl) + PW'(tkl);

  // ---------------------------------------------------------------------
  // Stage 2: tap sum registered; stage 3: running sum is the output
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]          s2_partial;
  logic                          s2_start;
  logic signed [SHAPED_BITS-1:0] running_sum;
  logic signed [SHAPED_BITS-1:0] sum_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_partial <= partial;
      s2_start   <= s1_start;
    end
  end

  // start of record drops the previous sum; wraps mod 2^SHAPED_BITS
  assign sum_base = s2_start ? '0 : running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3          <= 1'b0;
      running_sum <= '0;
    end else if (en3) begin
      v3 <= v2;
      if (v2) begin
        running_sum <= sum_base + SHAPED_BITS'(s2_partial);
      end
    end
  end

  assign shaped_ch.valid  = v3;
  assign shaped_ch.shaped = running_sum;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_ALWAYS(a_fill_bound, fill_count <= FC_MAX, "fill count beyond history depth")
  `ASSERT_NEXT(a_start_fill, in_fire && sample_ch.start_req, fill_count == AW'(1), "fill not reset")
  `ASSERT_NEXT(a_wp_step, in_fire && wp != WP_MAX, wp == $past(wp) + 1'b1, "wp did not step")
  `ASSERT_NEXT(a_s1_hold, v1 && !en2, v1 && $stable(s1_sample), "stage 1 item lost")
  `ASSERT_NEXT(a_sum_hold, !(v2 && en3), $stable(running_sum), "running sum moved")

endmodule

// ===== tb/trapezoidal_pulse_shaper_tb.sv =====
`timescale 1ns / 1ps
module trapezoidal_pulse_shaper_tb;
  import tps_pkg::*;

  localparam int HISTORY_DEPTH = 8192;
  localparam int SAMPLE_BITS   = 16;
  localparam int HOLD_CYCLES   = 80;     // long receiver hold-off
  localparam int DRAIN_CYCLES  = 10;     // pipeline is 3 deep

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SHAPED_BITS-1:0] shaped_t;
  typedef logic [DELAY_BITS-1:0]         delay_t;

  // one directed step: register setting it runs under, input, and
  // (when known) the typed-in result
  typedef struct packed {
    delay_t  k;
    delay_t  l;
    sample_t sample;
    logic    start;
    logic    known;
    shaped_t want;
  } step_row_t;

  typedef struct packed {
    logic    known;
    shaped_t want;
  } typed_result_t;

  // Directed steps. First rows run on the reset values of rise_k/delay_l, so
  // every tap is still beyond the record and the output is a plain running sum.
  // With k = 0 and l = 0 all taps read the current sample and the sum stays put;
  // with l = 0 the two inner taps cancel the outer ones, same result.
  localparam step_row_t DIRECTED_STEPS [20] = '{
    '{12'd2500, 12'd3000, 16'sh7FFF, 1'b1, 1'b1,  29'sd32767},
    '{12'd2500, 12'd3000, 16'sh8000, 1'b0, 1'b1, -29'sd1},
    '{12'd2500, 12'd3000, 16'sh0000, 1'b0, 1'b1, -29'sd1},
    '{12'd2500, 12'd3000, 16'sh8000, 1'b1, 1'b1, -29'sd32768},   // restart mid-record
    '{12'd2500, 12'd3000, 16'sh0001, 1'b1, 1'b1,  29'sd1},
    '{12'd2500, 12'd3000, 16'sh5555, 1'b0, 1'b1,  29'sd21846},
    '{12'd2500, 12'd3000, 16'shAAAA, 1'b0, 1'b1,  29'sd0},
    '{12'd0,    12'd0,    16'sd12345, 1'b1, 1'b1, 29'sd0},       // zero delay taps
    '{12'd0,    12'd0,    16'sh8000, 1'b0, 1'b1,  29'sd0},
    '{12'd0,    12'd0,    16'sh7FFF, 1'b0, 1'b1,  29'sd0},
    '{12'd1,    12'd1,    16'sd100,  1'b1, 1'b1,  29'sd100},
    '{12'd1,    12'd1,    16'sd50,   1'b0, 1'b1, -29'sd50},
    '{12'd1,    12'd1,    16'sd7,    1'b0, 1'b0,  29'sd0},
    '{12'd2,    12'd0,    16'sd1000, 1'b1, 1'b1,  29'sd0},
    '{12'd2,    12'd0,    16'sh8000, 1'b0, 1'b1,  29'sd0},
    '{12'd4095, 12'd4095, 16'sh8000, 1'b1, 1'b1, -29'sd32768},   // longest taps
    '{12'd4095, 12'd4095, 16'sh7FFF, 1'b0, 1'b1, -29'sd1},
    '{12'd4095, 12'd4095, 16'sh0001, 1'b0, 1'b1,  29'sd0},
    '{12'd4095, 12'd1,    16'sd5,    1'b1, 1'b1,  29'sd5},
    '{12'd4095, 12'd1,    16'sd7,    1'b0, 1'b0,  29'sd0}
  };

  // Register settings for the random phases: short taps so records reach past
  // every tap, zero-delay corners, and the largest values with short records.
  localparam int N_PHASES = 9;
  localparam delay_t PHASE_K [N_PHASES] =
    '{12'd1, 12'd3, 12'd2, 12'd0, 12'd6, 12'd0, 12'd12, 12'd1,    12'd4095};
  localparam delay_t PHASE_L [N_PHASES] =
    '{12'd1, 12'd8, 12'd2, 12'd5, 12'd0, 12'd0, 12'd4,  12'd4095, 12'd3};
  localparam int PHASE_ITEMS = 125;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tps_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  tps_out_if                             shaped_ch ();

  trapezoidal_pulse_shaper #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .shaped_ch(shaped_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shaper model: own copy of history ring, fill count, write pointer, running
  // sum and the two registers. Updated on every accepted input transfer.
  // ---------------------------------------------------------------------------
  sample_t       sample_ring [HISTORY_DEPTH];
  int unsigned   fill_count = 0;
  int unsigned   ring_wr    = 0;
  shaped_t       shaped_sum = '0;
  delay_t        cur_k      = RISE_K_RESET;
  delay_t        cur_l      = DELAY_L_RESET;

  shaped_t       pending_shaped [$];   // predicted results, oldest first
  typed_result_t directed_want  [$];   // typed-in results of the directed steps
  int            errors = 0;

  // sender / receiver pacing
  bit            gaps_on  = 1'b1;
  int            burst_left = 0;
  bit            hold_req = 1'b0;

  // Tap d samples back. Zero delay reads the current sample; anything older
  // than the record start (or the ring) reads zero.
  function automatic sample_t tap_value(int unsigned d, sample_t cur);
    if (d == 0) return cur;
    if (d > fill_count || d >= HISTORY_DEPTH) return '0;
    return sample_ring[(ring_wr + HISTORY_DEPTH - d) % HISTORY_DEPTH];
  endfunction

  task automatic predict_shaped(sample_t s, logic st);
    int acc;
    if (st) begin
      fill_count = 0;
      shaped_sum = '0;
    end
    acc = int'(shaped_sum) + int'(s)
          - int'(tap_value(cur_k, s)) - int'(tap_value(cur_l, s))
          + int'(tap_value(int'(cur_k) + int'(cur_l), s));
    shaped_sum = acc[SHAPED_BITS-1:0];      // wraps modulo 2^29
    sample_ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
    if (fill_count < HISTORY_DEPTH - 1) fill_count++;
    pending_shaped.insert(pending_shaped.size(), shaped_sum);
  endtask

  task automatic note_error(string what, shaped_t want, shaped_t got);
    errors++;
    $display("%0t ns: %s: expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic check_shaped(shaped_t got);
    shaped_t       want;
    typed_result_t row;
    if (pending_shaped.size() == 0) begin
      note_error("result with no transfer pending", 'x, got);
      return;
    end
    want = pending_shaped.pop_front();
    if (got !== want) note_error("shaped mismatch", want, got);
    // directed steps come first, so their results are the first ones out
    if (directed_want.size() != 0) begin
      row = directed_want.pop_front();
      if (row.known && got !== row.want) note_error("directed shaped mismatch", row.want, got);
    end
  endtask

  // Both channels sampled at the rising edge; inputs only move at the falling one.
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      predict_shaped(sample_ch.sample, sample_ch.start_req);
    if (!rst && shaped_ch.valid && shaped_ch.ready)
      check_shaped(shaped_ch.shaped);
  end

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, holds the transfer until accepted. Bursts
  // of random length, random gaps between them; valid stays high across a burst.
  // ---------------------------------------------------------------------------
  task automatic send_sample(sample_t s, logic st);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample    <= s;
    sample_ch.start_req <= st;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  // Sender pauses until every predicted result has come back.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_shaped.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // APB access: setup cycle, then access cycle until pready. Drops psel and idles
  // before returning, so back-to-back calls never touch psel twice in one step.
  task automatic apb_access(logic wr, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Idle the shaper, write both registers (junk in the unused upper bits) and
  // read each one back.
  task automatic set_shape(delay_t k, delay_t l);
    delay_t      val [2];
    logic        idx;
    logic [19:0] junk;
    logic [31:0] rd;
    val[0] = k;
    val[1] = l;
    drain_results();
    for (int r = 0; r < 2; r++) begin
      idx  = (r == 0) ? REG_RISE_K : REG_DELAY_L;
      junk = 20'($urandom);
      apb_access(1'b1, idx, {junk, val[r]}, rd);
      apb_access(1'b0, idx, '0, rd);
      if (rd[DELAY_BITS-1:0] !== val[r]) begin
        errors++;
        $display("%0t ns: register %0d readback: expected %0d, actual %0d",
                 $time, r, val[r], rd[DELAY_BITS-1:0]);
      end
    end
    cur_k = k;
    cur_l = l;
  endtask

  // Full-scale extremes, small values near zero, or any 16-bit pattern.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Records of random length. Most open with a start request; a few carry on the
  // previous record, and now and then a start lands mid-record.
  task automatic run_records(int n_items, int min_len, int max_len);
    int sent;
    int len;
    logic st;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(min_len, max_len);
      for (int i = 0; i < len && sent < n_items; i++) begin
        st = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0);
        send_sample(pick_sample(), st);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a pattern whose mode (always ready, mostly ready,
  // periodic, coin flip) is picked anew at random when its run ends. On request
  // it holds ready low so the pipeline fills and input ready drops.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    shaped_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        shaped_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(50, 300);
        end
        left--;
        case (mode)
          0:       shaped_ch.ready <= 1'b1;
          1:       shaped_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       shaped_ch.ready <= ((left % 8) >= 3);
          default: shaped_ch.ready <= 1'($urandom_range(0, 1));
        endcase
        @(negedge clk);
      end
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    typed_result_t rec;
    sample_ch.valid     = 1'b0;
    sample_ch.sample    = '0;
    sample_ch.start_req = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed steps; registers only rewritten when the row asks for a new
    // setting, so the first rows check the reset values.
    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].k != cur_k || DIRECTED_STEPS[i].l != cur_l)
        set_shape(DIRECTED_STEPS[i].k, DIRECTED_STEPS[i].l);
      rec.known = DIRECTED_STEPS[i].known;
      rec.want  = DIRECTED_STEPS[i].want;
      directed_want.insert(directed_want.size(), rec);
      send_sample(DIRECTED_STEPS[i].sample, DIRECTED_STEPS[i].start);
    end

    // Random records under each setting. Some phases run without sender gaps;
    // the third one also holds off the receiver for a long stretch while the
    // sender keeps pushing, so the shaper backs up into its input.
    for (int p = 0; p < N_PHASES; p++) begin
      set_shape(PHASE_K[p], PHASE_L[p]);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      run_records(PHASE_ITEMS, 1, int'(PHASE_K[p]) + int'(PHASE_L[p]) + 16);
    end
    gaps_on = 1'b1;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
